>>> hdl/dft2d_pkg.sv
// Package for the 2-D DFT block: sizes, state encoding and twiddle table.
// No dependencies.
package dft2d_pkg;
    localparam int SIDE = 128;
    localparam int LG = $clog2(SIDE);
    localparam int AW = 2 * LG;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_DRAIN, S_SQRT, S_OUT
    } t_state;

    // Q30 sum rounded half up to Q15, clamped to [0, 32767]
    function automatic logic [15:0] q30_to_q15(input longint v);
        longint r;
        r = (v < 0) ? 64'sd0 : v;
        r = (r + 64'sd16384) >>> 15;
        if (r > 64'sd32767) r = 64'sd32767;
        return r[15:0];
    endfunction

    // Twiddle i in Q1.15, cos in [31:16], sin in [15:0]. The quarter turn is
    // folded to [0, pi/4], sin and cos are truncated Taylor sums in Q30, then
    // the pair is signed by quadrant.
    function automatic logic [31:0] make_twiddle(input int i);
        longint unsigned u, quad, r, x, x2, term;
        longint s, c;
        logic [15:0] cq, sq, t;
        logic swap;
        u = 64'(i) << (32 - LG);
        quad = (u >> 30) & 64'd3;
        r = u & 64'h3FFF_FFFF;
        swap = 1'b0;
        if (r > 64'h2000_0000) begin
            r = 64'h4000_0000 - r;
            swap = 1'b1;
        end
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        s = longint'(x);
        for (int n = 1; n <= 4; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) s -= longint'(term); else s += longint'(term);
        end
        term = 64'h4000_0000;
        c = 64'sh4000_0000;
        for (int n = 1; n <= 4; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n[0]) c -= longint'(term); else c += longint'(term);
        end
        cq = q30_to_q15(c);
        sq = q30_to_q15(s);
        if (swap) begin
            t = cq;
            cq = sq;
            sq = t;
        end
        case (quad[1:0])
            2'd0: return {cq, sq};
            2'd1: return {-sq, cq};
            2'd2: return {-cq, -sq};
            default: return {sq, -cq};
        endcase
    endfunction

    // whole table, entry i at [i*32 +: 32]
    function automatic logic [SIDE*32-1:0] twiddle_table();
        logic [SIDE*32-1:0] tab;
        tab = '0;
        for (int i = 0; i < SIDE; i++) tab[i*32 +: 32] = make_twiddle(i);
        return tab;
    endfunction

    localparam logic [SIDE*32-1:0] TW_TABLE = twiddle_table();
endpackage

>>> hdl/dft_2d_square_image_top.sv
// Top level of the 2-D DFT block: sample store, complex MAC, root unit.
// Depends on dft2d_pkg.
// A load writes one sample into the store. A compute sweeps all SIDE*SIDE samples
// through the MAC (one read port, one complex multiply per cycle), drains the MAC
// pipe and runs a bit-serial square root (17 root bits, then a step to form the
// pixel) before the result is valid.
// Loads are taken back to back while idle; nothing is taken until the result is taken.
// Reset: synchronous active low; clears control and direction, not the store.
module dft_2d_square_image_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic [6:0]         i_row,
    input  logic [6:0]         i_column,
    input  logic signed [23:0] i_value_real,
    input  logic signed [23:0] i_value_imag,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_out_real,
    output logic signed [23:0] o_out_imag,
    output logic [7:0]         o_out_pixel,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import dft2d_pkg::*;

    logic [47:0] mem [SIDE*SIDE];
    t_state r_state, n_state;
    logic r_dir;
    logic [AW:0] r_cnt, n_cnt;
    logic [LG-1:0] r_k, r_l, r_ph, r_rb, n_ph, n_rb;
    logic [47:0] r_rd;
    logic r_v1, r_v2;
    logic [31:0] r_tw;
    logic signed [63:0] r_accr, r_acci, r_pr, r_pi;
    logic signed [23:0] r_or, r_oi;
    logic [7:0] r_px;
    logic [33:0] r_sv, r_sres, r_sbit;
    logic r_big;
    logic signed [63:0] re_f, im_f;
    logic signed [47:0] re_s, im_s;
    logic [16:0] ar, ai;
    logic in_acc;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_out_real = r_or;
    assign o_out_imag = r_oi;
    assign o_out_pixel = r_px;

    // store: one write port for loads, one read for the sweep
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_command)
            mem[{i_row[LG-1:0], i_column[LG-1:0]}] <= {i_value_real, i_value_imag};
        r_rd <= mem[r_cnt[AW-1:0]];
        r_tw <= TW_TABLE[{r_ph, 5'b0} +: 32];
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_ph = r_ph;
        n_rb = r_rb;
        case (r_state)
            S_IDLE: if (in_acc && i_command) begin
                n_state = S_RUN;
                n_cnt = '0;
                n_ph = '0;
                n_rb = '0;
            end
            S_RUN: begin
                // phase steps by k along a row, row base by l per row
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[LG-1:0] == LG'(SIDE - 1)) begin
                    n_rb = r_rb + r_l;
                    n_ph = r_rb + r_l;
                end else begin
                    n_ph = r_ph + r_k;
                end
                if (r_cnt == (AW+1)'(SIDE*SIDE - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: if (!r_v1 && !r_v2) n_state = S_SQRT;
            S_SQRT: if (r_sbit == '0) n_state = S_OUT;
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dir <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_dir <= i_cfg_data;
            r_v1 <= (r_state == S_RUN);
            r_v2 <= r_v1;
        end
    end

    logic signed [15:0] tc, ts;
    logic signed [23:0] sa, sb;
    assign tc = r_tw[31:16];
    assign ts = r_dir ? r_tw[15:0] : -r_tw[15:0];
    assign sa = r_rd[47:24];
    assign sb = r_rd[23:0];
    assign re_f = r_accr >>> (LG + 15);
    assign im_f = r_acci >>> (LG + 15);
    assign re_s = re_f[47:0];
    assign im_s = im_f[47:0];
    assign ar = re_f[63] ? 17'(-re_f) : 17'(re_f);
    assign ai = im_f[63] ? 17'(-im_f) : 17'(im_f);

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_ph <= n_ph;
        r_rb <= n_rb;
        if (in_acc && i_command) begin
            r_k <= i_column[LG-1:0];
            r_l <= i_row[LG-1:0];
            r_accr <= '0;
            r_acci <= '0;
        end
        if (r_v1) begin
            r_pr <= 64'(sa * tc) - 64'(sb * ts);
            r_pi <= 64'(sa * ts) + 64'(sb * tc);
        end
        if (r_v2) begin
            r_accr <= r_accr + r_pr;
            r_acci <= r_acci + r_pi;
        end
        if (r_state == S_DRAIN && !r_v1 && !r_v2) begin
            r_or <= (re_f > 64'sd8388607) ? 24'sh7fffff :
                    (re_f < -64'sd8388608) ? 24'sh800000 : re_s[23:0];
            r_oi <= (im_f > 64'sd8388607) ? 24'sh7fffff :
                    (im_f < -64'sd8388608) ? 24'sh800000 : im_s[23:0];
            r_big <= (re_f >= 64'sd65536) || (re_f <= -64'sd65536) ||
                     (im_f >= 64'sd65536) || (im_f <= -64'sd65536);
            r_sv <= 34'(ar[15:0] * ar[15:0]) + 34'(ai[15:0] * ai[15:0]);
            r_sres <= '0;
            r_sbit <= 34'h1 << 32;
        end
        if (r_state == S_SQRT) begin
            // one root bit per cycle
            if (r_sbit != '0) begin
                if (r_sv >= r_sres + r_sbit) begin
                    r_sv <= r_sv - (r_sres + r_sbit);
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end else begin
                r_px <= !r_dir ? 8'd0 : (r_big || r_sres[33:16] != '0) ? 8'd255 :
                        r_sres[15:8];
            end
        end
    end
endmodule
